FILE: design/quadratic_root_solver_unit_defines.svh
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH

// implication checked on every edge outside reset
`define QRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/qrs_pkg.sv
`default_nettype none

package qrs_pkg;

    localparam int COEF_WIDTH     = 16;
    localparam int ROOT_FRAC_BITS = 16;
    localparam int COEF_FRAC      = 8;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_DOUBLE = 2'd1,
        ST_TWO    = 2'd2,
        ST_A_ZERO = 2'd3
    } root_status_t;

    function automatic int max_int(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

endpackage

`default_nettype wire

FILE: design/qrs_front.sv
`default_nettype none

module qrs_front #(
    parameter int CW  = qrs_pkg::COEF_WIDTH,
    parameter int RFB = qrs_pkg::ROOT_FRAC_BITS,
    parameter int DW  = 2 * CW + 2,
    parameter int XW  = 50
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [CW-1:0] in_a,
    input  wire logic signed [CW-1:0] in_b,
    input  wire logic signed [CW-1:0] in_c,
    output logic                      out_valid,
    output logic [XW-1:0]             out_x,
    output logic signed [DW-1:0]      out_d,
    output qrs_pkg::root_status_t     out_status,
    output logic signed [CW-1:0]      out_a,
    output logic signed [CW-1:0]      out_b
);

    localparam int SHIFT = 2 * (RFB - qrs_pkg::COEF_FRAC);

    logic                     v1_reg;
    logic signed [2*CW-1:0]   bb_reg;
    logic signed [2*CW-1:0]   ac_reg;
    logic signed [CW-1:0]     a1_reg;
    logic signed [CW-1:0]     b1_reg;

    logic                     v2_reg;
    logic [XW-1:0]            x_reg;
    logic signed [DW-1:0]     d_reg;
    qrs_pkg::root_status_t    st_reg;
    logic signed [CW-1:0]     a2_reg;
    logic signed [CW-1:0]     b2_reg;

    logic signed [DW-1:0]     d_next;
    logic [XW-1:0]            x_next;
    qrs_pkg::root_status_t    st_next;

    always_comb begin
        d_next = {{2{bb_reg[2*CW-1]}}, bb_reg} - ({{2{ac_reg[2*CW-1]}}, ac_reg} <<< 2);
        x_next = XW'(d_next[DW-2:0]) << SHIFT;
        priority if (a1_reg == '0) begin
            st_next = qrs_pkg::ST_A_ZERO;
        end else if (d_next[DW-1]) begin
            st_next = qrs_pkg::ST_NONE;
        end else if (d_next == '0) begin
            st_next = qrs_pkg::ST_DOUBLE;
        end else begin
            st_next = qrs_pkg::ST_TWO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bb_reg <= in_b * in_b;
            ac_reg <= in_a * in_c;
            a1_reg <= in_a;
            b1_reg <= in_b;
            x_reg  <= x_next;
            d_reg  <= d_next;
            st_reg <= st_next;
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
        end
    end

    assign out_valid  = v2_reg;
    assign out_x      = x_reg;
    assign out_d      = d_reg;
    assign out_status = st_reg;
    assign out_a      = a2_reg;
    assign out_b      = b2_reg;

endmodule

`default_nettype wire

FILE: design/qrs_sqrt.sv
`default_nettype none

module qrs_sqrt #(
    parameter int XW     = 50,
    parameter int SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [XW-1:0]     in_x,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [XW/2-1:0]        out_root,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int SR = XW / 2;

    logic [SR-1:0]     v_reg;
    logic [XW-1:0]     x_reg    [SR];
    logic [SR:0]       r_reg    [SR];
    logic [SR-1:0]     q_reg    [SR];
    logic [SIDE_W-1:0] side_reg [SR];

    for (genvar k = 0; k < SR; k++) begin : g_stage
        logic [XW-1:0]     x_p;
        logic [SR:0]       r_p;
        logic [SR-1:0]     q_p;
        logic              v_p;
        logic [SIDE_W-1:0] side_p;
        logic [SR+2:0]     r_sh;
        logic [SR+2:0]     trial;
        logic [SR+2:0]     r_new;
        logic              ge;

        if (k == 0) begin : g_first
            assign x_p    = in_x;
            assign r_p    = '0;
            assign q_p    = '0;
            assign v_p    = in_valid;
            assign side_p = in_side;
        end else begin : g_next
            assign x_p    = x_reg[k-1];
            assign r_p    = r_reg[k-1];
            assign q_p    = q_reg[k-1];
            assign v_p    = v_reg[k-1];
            assign side_p = side_reg[k-1];
        end

        assign r_sh  = {r_p, x_p[XW-1 -: 2]};
        assign trial = {1'b0, q_p, 2'b01};
        assign ge    = (r_sh >= trial);
        assign r_new = ge ? (r_sh - trial) : r_sh;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_p;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k]    <= x_p << 2;
                r_reg[k]    <= r_new[SR:0];
                q_reg[k]    <= {q_p[SR-2:0], ge};
                side_reg[k] <= side_p;
            end
        end
    end

    assign out_valid = v_reg[SR-1];
    assign out_root  = q_reg[SR-1];
    assign out_side  = side_reg[SR-1];

endmodule

`default_nettype wire

FILE: design/qrs_div.sv
`default_nettype none

module qrs_div #(
    parameter int NW     = 35,
    parameter int DENW   = 17,
    parameter int SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NW-1:0]     in_num_p,
    input  wire logic [NW-1:0]     in_num_m,
    input  wire logic [DENW-1:0]   in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [NW-1:0]          out_quot_p,
    output logic [NW-1:0]          out_quot_m,
    output logic [SIDE_W-1:0]      out_side
);

    logic [NW-1:0]     v_reg;
    logic [NW-1:0]     np_reg   [NW];
    logic [NW-1:0]     nm_reg   [NW];
    logic [DENW-1:0]   rp_reg   [NW];
    logic [DENW-1:0]   rm_reg   [NW];
    logic [DENW-1:0]   den_reg  [NW];
    logic [SIDE_W-1:0] side_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [NW-1:0]     np_p;
        logic [NW-1:0]     nm_p;
        logic [DENW-1:0]   rp_p;
        logic [DENW-1:0]   rm_p;
        logic [DENW-1:0]   den_p;
        logic              v_p;
        logic [SIDE_W-1:0] side_p;
        logic [DENW:0]     rp_sh;
        logic [DENW:0]     rm_sh;
        logic [DENW:0]     rp_new;
        logic [DENW:0]     rm_new;
        logic              gep;
        logic              gem;

        if (k == 0) begin : g_first
            assign np_p   = in_num_p;
            assign nm_p   = in_num_m;
            assign rp_p   = '0;
            assign rm_p   = '0;
            assign den_p  = in_den;
            assign v_p    = in_valid;
            assign side_p = in_side;
        end else begin : g_next
            assign np_p   = np_reg[k-1];
            assign nm_p   = nm_reg[k-1];
            assign rp_p   = rp_reg[k-1];
            assign rm_p   = rm_reg[k-1];
            assign den_p  = den_reg[k-1];
            assign v_p    = v_reg[k-1];
            assign side_p = side_reg[k-1];
        end

        // quotient bits shift in where numerator bits leave
        assign rp_sh  = {rp_p, np_p[NW-1]};
        assign rm_sh  = {rm_p, nm_p[NW-1]};
        assign gep    = (rp_sh >= {1'b0, den_p});
        assign gem    = (rm_sh >= {1'b0, den_p});
        assign rp_new = gep ? (rp_sh - {1'b0, den_p}) : rp_sh;
        assign rm_new = gem ? (rm_sh - {1'b0, den_p}) : rm_sh;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_p;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                np_reg[k]   <= {np_p[NW-2:0], gep};
                nm_reg[k]   <= {nm_p[NW-2:0], gem};
                rp_reg[k]   <= rp_new[DENW-1:0];
                rm_reg[k]   <= rm_new[DENW-1:0];
                den_reg[k]  <= den_p;
                side_reg[k] <= side_p;
            end
        end
    end

    assign out_valid  = v_reg[NW-1];
    assign out_quot_p = np_reg[NW-1];
    assign out_quot_m = nm_reg[NW-1];
    assign out_side   = side_reg[NW-1];

endmodule

`default_nettype wire

FILE: design/quadratic_root_solver_unit.sv
// channel | direction | ports
// s_      | in        | s_valid s_ready s_coef_a s_coef_b s_coef_c
// m_      | out       | m_valid m_ready m_root_status m_discriminant m_root_plus m_root_minus
//
// one transfer is taken per cycle unless the output stalls; path: front end, square
// root (SR = 25 stages), numerator register, divider (NW = 35 stages), output register
// aresetn clears every valid bit; no clearing pass
// the whole pipeline freezes while m_valid is high and m_ready low; nothing is lost
`default_nettype none

`include "quadratic_root_solver_unit_defines.svh"

module quadratic_root_solver_unit #(
    parameter int COEF_WIDTH     = qrs_pkg::COEF_WIDTH,
    parameter int ROOT_FRAC_BITS = qrs_pkg::ROOT_FRAC_BITS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [COEF_WIDTH-1:0] s_coef_a,
    input  wire logic signed [COEF_WIDTH-1:0] s_coef_b,
    input  wire logic signed [COEF_WIDTH-1:0] s_coef_c,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [1:0]                        m_root_status,
    output logic signed [2*COEF_WIDTH+1:0]    m_discriminant,
    output logic signed [ROOT_FRAC_BITS+31:0] m_root_plus,
    output logic signed [ROOT_FRAC_BITS+31:0] m_root_minus
);

    localparam int CW     = COEF_WIDTH;
    localparam int RFB    = ROOT_FRAC_BITS;
    localparam int CF     = qrs_pkg::COEF_FRAC;
    localparam int DW     = 2 * CW + 2;
    localparam int RW     = 32 + RFB;
    localparam int XRAW   = DW - 1 + 2 * (RFB - CF);
    localparam int XW     = XRAW + (XRAW % 2);
    localparam int SR     = XW / 2;
    localparam int NBW    = CW + 1 + RFB - CF;
    localparam int SUMW   = qrs_pkg::max_int(NBW, SR + 1) + 1 + CF;
    localparam int DENW   = CW + 1;
    localparam int CMPW   = qrs_pkg::max_int(SUMW, RW) + 1;
    localparam int SQ_SW  = 2 + DW + 2 * CW;
    localparam int DV_SW  = 2 + DW + 2;

    logic en;

    logic                  f_valid;
    logic [XW-1:0]         f_x;
    logic signed [DW-1:0]  f_d;
    qrs_pkg::root_status_t f_status;
    logic signed [CW-1:0]  f_a;
    logic signed [CW-1:0]  f_b;

    logic                  q_valid;
    logic [SR-1:0]         q_root;
    logic [SQ_SW-1:0]      q_side;
    logic [1:0]            q_st;
    logic [DW-1:0]         q_d;
    logic [CW-1:0]         q_a;
    logic [CW-1:0]         q_b;

    logic                  p_valid_reg;
    logic [SUMW-1:0]       p_np_reg;
    logic [SUMW-1:0]       p_nm_reg;
    logic [DENW-1:0]       p_den_reg;
    logic [DV_SW-1:0]      p_side_reg;

    logic [SUMW-1:0]       b_ext;
    logic [SUMW-1:0]       nb;
    logic [SUMW-1:0]       s_ext;
    logic [SUMW-1:0]       sum_p;
    logic [SUMW-1:0]       sum_m;
    logic [DENW-1:0]       den2;
    logic [DENW-1:0]       den_mag;
    logic                  neg_p;
    logic                  neg_m;

    logic                  v_valid;
    logic [SUMW-1:0]       v_qp;
    logic [SUMW-1:0]       v_qm;
    logic [DV_SW-1:0]      v_side;
    logic [1:0]            v_st;
    logic [DW-1:0]         v_d;
    logic                  v_neg_p;
    logic                  v_neg_m;

    logic                  m_valid_reg;
    logic [1:0]            m_st_reg;
    logic [DW-1:0]         m_d_reg;
    logic [RW-1:0]         m_rp_reg;
    logic [RW-1:0]         m_rm_reg;
    logic [RW-1:0]         rp_next;
    logic [RW-1:0]         rm_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    qrs_front #(
        .CW  (CW),
        .RFB (RFB),
        .DW  (DW),
        .XW  (XW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .in_a       (s_coef_a),
        .in_b       (s_coef_b),
        .in_c       (s_coef_c),
        .out_valid  (f_valid),
        .out_x      (f_x),
        .out_d      (f_d),
        .out_status (f_status),
        .out_a      (f_a),
        .out_b      (f_b)
    );

    qrs_sqrt #(
        .XW     (XW),
        .SIDE_W (SQ_SW)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_x      (f_x),
        .in_side   ({f_status, f_d, f_a, f_b}),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_side  (q_side)
    );

    assign {q_st, q_d, q_a, q_b} = q_side;

    // numerators and divisor magnitude ahead of the divider
    always_comb begin
        b_ext   = {{(SUMW-CW){q_b[CW-1]}}, q_b};
        nb      = (SUMW'(0) - b_ext) << (RFB - CF);
        s_ext   = SUMW'(q_root);
        sum_p   = (nb + s_ext) << CF;
        sum_m   = (nb - s_ext) << CF;
        den2    = {q_a, 1'b0};
        den_mag = q_a[CW-1] ? (DENW'(0) - den2) : den2;
        neg_p   = sum_p[SUMW-1] ^ q_a[CW-1];
        neg_m   = sum_m[SUMW-1] ^ q_a[CW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_np_reg   <= sum_p[SUMW-1] ? (SUMW'(0) - sum_p) : sum_p;
            p_nm_reg   <= sum_m[SUMW-1] ? (SUMW'(0) - sum_m) : sum_m;
            p_den_reg  <= den_mag;
            p_side_reg <= {q_st, q_d, neg_p, neg_m};
        end
    end

    qrs_div #(
        .NW     (SUMW),
        .DENW   (DENW),
        .SIDE_W (DV_SW)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (p_valid_reg),
        .in_num_p   (p_np_reg),
        .in_num_m   (p_nm_reg),
        .in_den     (p_den_reg),
        .in_side    (p_side_reg),
        .out_valid  (v_valid),
        .out_quot_p (v_qp),
        .out_quot_m (v_qm),
        .out_side   (v_side)
    );

    assign {v_st, v_d, v_neg_p, v_neg_m} = v_side;

    function automatic logic [RW-1:0] sat_root(input logic [SUMW-1:0] q, input logic neg);
        logic [CMPW-1:0] qx;
        logic [CMPW-1:0] lim;
        logic [CMPW-1:0] r;
        qx  = CMPW'(q);
        lim = CMPW'(1) << (RW - 1);
        if (neg) begin
            r = (qx > lim) ? lim : qx;
            r = CMPW'(0) - r;
        end else begin
            r = (qx > lim - CMPW'(1)) ? (lim - CMPW'(1)) : qx;
        end
        return r[RW-1:0];
    endfunction

    always_comb begin
        if (v_st == qrs_pkg::ST_DOUBLE || v_st == qrs_pkg::ST_TWO) begin
            rp_next = sat_root(v_qp, v_neg_p);
            rm_next = sat_root(v_qm, v_neg_m);
        end else begin
            rp_next = '0;
            rm_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_st_reg <= v_st;
            m_d_reg  <= v_d;
            m_rp_reg <= rp_next;
            m_rm_reg <= rm_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_root_status  = m_st_reg;
    assign m_discriminant = m_d_reg;
    assign m_root_plus    = m_rp_reg;
    assign m_root_minus   = m_rm_reg;

    `QRS_ASSERT_IMP(a_zero_no_roots,
        m_valid && (m_root_status == qrs_pkg::ST_A_ZERO || m_root_status == qrs_pkg::ST_NONE),
        m_root_plus == '0 && m_root_minus == '0, "roots not zero without real roots")
    `QRS_ASSERT_IMP(a_none_neg_disc, m_valid && m_root_status == qrs_pkg::ST_NONE,
        m_discriminant[DW-1], "no-root status with non-negative discriminant")
    `QRS_ASSERT_IMP(a_double_equal, m_valid && m_root_status == qrs_pkg::ST_DOUBLE,
        m_root_plus == m_root_minus && m_discriminant == '0, "double root mismatch")
    `QRS_ASSERT_NEXT(a_stall_freeze, m_valid && !m_ready && !s_ready,
        $stable(m_root_plus) && $stable(m_discriminant), "pipeline moved during stall")

endmodule

`default_nettype wire

FILE: test/quadratic_root_solver_unit_test.sv
`default_nettype none

module quadratic_root_solver_unit_test;

    localparam int DW = 2 * qrs_pkg::COEF_WIDTH + 2;
    localparam int RW = 32 + qrs_pkg::ROOT_FRAC_BITS;
    localparam int LATENCY = 64;
    localparam int STALL_LIMIT = 20000;
    localparam int N_RANDOM = 400;

    typedef struct packed {
        logic [1:0]            status;
        logic signed [DW-1:0]  disc;
        logic signed [RW-1:0]  rplus;
        logic signed [RW-1:0]  rminus;
    } roots_t;

    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        bit                 typed;
        roots_t             res;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [qrs_pkg::COEF_WIDTH-1:0] s_coef_a = '0;
    logic signed [qrs_pkg::COEF_WIDTH-1:0] s_coef_b = '0;
    logic signed [qrs_pkg::COEF_WIDTH-1:0] s_coef_c = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_root_status;
    logic signed [DW-1:0] m_discriminant;
    logic signed [RW-1:0] m_root_plus;
    logic signed [RW-1:0] m_root_minus;

    roots_t pending_roots[$];
    int errors = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off = 1'b0;

    quadratic_root_solver_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_coef_a(s_coef_a), .s_coef_b(s_coef_b), .s_coef_c(s_coef_c),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_root_status(m_root_status), .m_discriminant(m_discriminant),
        .m_root_plus(m_root_plus), .m_root_minus(m_root_minus)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bt;
        r = '0;
        bt = 64'd1 << 62;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= r + bt) begin
                x = x - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [RW-1:0] quot_sat(input logic signed [63:0] n,
                                                      input logic signed [63:0] d);
        logic [63:0] mn;
        logic [63:0] md;
        logic [63:0] q;
        logic [63:0] lim;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        if (md == 0) return '0;
        q = mn / md;
        lim = 64'd1 << (RW - 1);
        if (n[63] != d[63]) begin
            if (q > lim) q = lim;
            return RW'(-q);
        end
        if (q > lim - 1) q = lim - 1;
        return RW'(q);
    endfunction

    function automatic roots_t solve_roots(input logic signed [15:0] a,
                                           input logic signed [15:0] b,
                                           input logic signed [15:0] c);
        roots_t r;
        logic signed [63:0] d;
        logic signed [63:0] s;
        logic signed [63:0] nb;
        logic signed [63:0] den;
        d = 64'(b) * 64'(b) - 64'sd4 * 64'(a) * 64'(c);
        r.status = qrs_pkg::ST_NONE;
        r.disc = DW'(d);
        r.rplus = '0;
        r.rminus = '0;
        if (a == 0) begin
            r.status = qrs_pkg::ST_A_ZERO;
        end else if (d >= 0) begin
            s = isqrt(d << (2 * qrs_pkg::ROOT_FRAC_BITS - 2 * qrs_pkg::COEF_FRAC));
            nb = (-64'(b)) <<< (qrs_pkg::ROOT_FRAC_BITS - qrs_pkg::COEF_FRAC);
            den = 64'(a) * 2;
            r.status = (d == 0) ? qrs_pkg::ST_DOUBLE : qrs_pkg::ST_TWO;
            r.rplus = quot_sat((nb + s) <<< qrs_pkg::COEF_FRAC, den);
            r.rminus = quot_sat((nb - s) <<< qrs_pkg::COEF_FRAC, den);
        end
        return r;
    endfunction

    task automatic send_coefs(input logic signed [15:0] a, input logic signed [15:0] b,
                              input logic signed [15:0] c, input roots_t res);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_coef_a <= a;
        s_coef_b <= b;
        s_coef_c <= c;
        pending_roots.push_back(res);
        do @(posedge aclk); while (!s_ready);
    endtask

    // receiver side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_off && !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // checking of each result transfer
    always @(posedge aclk) begin
        roots_t got;
        roots_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                got = '{m_root_status, m_discriminant, m_root_plus, m_root_minus};
                if (pending_roots.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = pending_roots.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                        errors++;
                    end
                    if (got.disc !== want.disc) begin
                        $display("%0t: disc exp %0d got %0d", $time, want.disc, got.disc);
                        errors++;
                    end
                    if (got.rplus !== want.rplus) begin
                        $display("%0t: root_plus exp %0d got %0d", $time, want.rplus,
                                 got.rplus);
                        errors++;
                    end
                    if (got.rminus !== want.rminus) begin
                        $display("%0t: root_minus exp %0d got %0d", $time, want.rminus,
                                 got.rminus);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL quadratic_root_solver_unit");
            $finish;
        end
    end

    initial begin
        row_t rows[$];
        row_t rw;
        roots_t res;
        int n;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b1, '{qrs_pkg::ST_A_ZERO, '0, '0, '0}});
        rows.push_back('{16'sd0, 16'sd256, 16'sd256, 1'b1,
                         '{qrs_pkg::ST_A_ZERO, 34'sd65536, '0, '0}});
        rows.push_back('{16'sd256, 16'sd0, 16'sd256, 1'b1,
                         '{qrs_pkg::ST_NONE, -34'sd262144, '0, '0}});
        rows.push_back('{16'sd256, 16'sd0, 16'sd0, 1'b1, '{qrs_pkg::ST_DOUBLE, '0, '0, '0}});
        rows.push_back('{16'sd256, 16'sd512, 16'sd256, 1'b0, '{default: '0}});
        rows.push_back('{16'sd256, 16'sd0, -16'sd1024, 1'b0, '{default: '0}});
        rows.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '{default: '0}});
        rows.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '{default: '0}});
        rows.push_back('{-16'sd32768, -16'sd32768, 16'sd32767, 1'b0, '{default: '0}});
        rows.push_back('{16'sd32767, -16'sd32768, -16'sd32768, 1'b0, '{default: '0}});
        rows.push_back('{16'sd1, -16'sd32768, 16'sd0, 1'b0, '{default: '0}});
        rows.push_back('{-16'sd1, 16'sd32767, 16'sd1, 1'b0, '{default: '0}});
        rows.push_back('{16'sd1, 16'sd32767, -16'sd32768, 1'b0, '{default: '0}});
        rows.push_back('{-16'sd1, 16'sd2, -16'sd1, 1'b0, '{default: '0}});
        rows.push_back('{16'sd0, -16'sd32768, 16'sd32767, 1'b0, '{default: '0}});
        foreach (rows[i]) begin
            rw = rows[i];
            res = rw.typed ? rw.res : solve_roots(rw.a, rw.b, rw.c);
            send_coefs(rw.a, rw.b, rw.c, res);
        end

        for (int ph = 0; ph < 5; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? 57 : ((ph == 4) ? 37 : 0);
            recv_idle_pct = (ph == 2) ? 57 : ((ph == 4) ? 37 : 0);
            if (ph == 0) fork
                begin
                    hold_off = 1'b1;
                    repeat (300) @(posedge aclk);
                    hold_off = 1'b0;
                end
            join_none
            for (int k = 0; k < N_RANDOM / 5; k++) begin
                n = $urandom_range(9);
                a = 16'($urandom);
                b = 16'($urandom);
                c = 16'($urandom);
                if (n == 0) a = '0;
                else if (n == 1) begin
                    a = 16'($urandom_range(512, 1));
                    b = 16'(2 * $urandom_range(1000));
                    c = 16'((b / 2) * (b / 2) / a);
                    if (n[0]) b = -b;
                end else if (n < 4) begin
                    a = 16'($urandom_range(300) - 150);
                    b = 16'($urandom_range(2000) - 1000);
                    c = 16'($urandom_range(300) - 150);
                end
                send_coefs(a, b, c, solve_roots(a, b, c));
            end
        end
        s_valid <= 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait (pending_roots.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS quadratic_root_solver_unit");
        end else begin
            $display("FAIL quadratic_root_solver_unit");
        end
        $finish;
    end

endmodule

`default_nettype wire
